// File: sv/bfiq_pkg.sv
// Shared constants, codes and controller/datapath interface types for the Bloom filter core.
`default_nettype none
package bfiq_pkg;

    // Store geometry
    localparam int MAX_FILTER_BYTES = 512;
    localparam int ADDR_W           = $clog2(MAX_FILTER_BYTES);
    localparam int BYTES_W          = $clog2(MAX_FILTER_BYTES + 1);
    localparam int MAX_PROBES       = 30;
    localparam int PROBE_W          = 5;
    localparam int MIN_FILTER_BITS  = 64;

    // Remainder is taken on hash bits 31..3 against the byte count
    localparam int HASH_W    = 32;
    localparam int DIV_STEPS = HASH_W - 3;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Field widths
    localparam int ACT_W      = 3;
    localparam int BPK_W      = 7;
    localparam int KEYS_W     = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_COUNT = 2'd2;

    // Controller states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_CLEAR,
        ST_DIV,
        ST_RD,
        ST_CHK,
        ST_BYTE,
        ST_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // capture the input word
        logic clr_step;   // zero one store byte, advance sweep address
        logic div_step;   // one restoring remainder step
        logic rd_probe;   // read the byte at the probe address
        logic probe_chk;  // set or test the probed bit, advance the hash
        logic rd_byte;    // read the byte at the requested address
        logic wr_byte;    // write the byte at the requested address
        logic set_err;    // flag an out-of-range address
        logic byte_cap;   // capture read data as result byte
        logic out_load;   // move the result into the output register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic               idx_ok;
        logic               bit_set;
        logic               clr_last;
        logic               out_busy;
        logic [PROBE_W-1:0] num_probes;
    } t_status;

endpackage
`default_nettype wire

// File: sv/bfiq_dpath.sv
// Datapath: configuration, filter store, remainder unit, probe hash and result registers.
`default_nettype none
module bfiq_dpath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire bfiq_pkg::t_cmd                  i_cmd,
    output bfiq_pkg::t_status                    o_status,
    input  wire logic [bfiq_pkg::ACT_W-1:0]      i_action,
    input  wire logic [bfiq_pkg::HASH_W-1:0]     i_key_hash,
    input  wire logic [bfiq_pkg::ADDR_W-1:0]     i_byte_index,
    input  wire logic [7:0]                      i_byte_value,
    input  wire logic                            i_cfg_valid,
    input  wire logic [bfiq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bfiq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output logic                                 o_may_match,
    output logic [7:0]                           o_byte_out,
    output logic                                 o_index_error
);

    // Configuration registers
    logic [bfiq_pkg::BPK_W-1:0]   r_key_bits;
    logic [bfiq_pkg::KEYS_W-1:0]  r_key_count;
    logic [bfiq_pkg::PROBE_W-1:0] r_probe_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bits    <= bfiq_pkg::BPK_W'(10);
            r_key_count   <= '0;
            r_probe_count <= bfiq_pkg::PROBE_W'(6);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bfiq_pkg::CFG_KEY_BITS:    r_key_bits    <= i_cfg_data[bfiq_pkg::BPK_W-1:0];
                bfiq_pkg::CFG_KEY_COUNT:   r_key_count   <= i_cfg_data[bfiq_pkg::KEYS_W-1:0];
                bfiq_pkg::CFG_PROBE_COUNT: r_probe_count <= i_cfg_data[bfiq_pkg::PROBE_W-1:0];
                default: ;
            endcase
        end
    end

    // Active byte count: keys x bits, floor of 64 bits, whole bytes, saturated
    logic [19:0]                  w_bits;
    logic [19:0]                  w_bits_min;
    logic [19:0]                  w_bytes_raw;
    logic [bfiq_pkg::BYTES_W-1:0] r_num_bytes;
    logic [bfiq_pkg::PROBE_W-1:0] w_num_probes;

    always_comb begin
        w_bits      = 20'(r_key_count) * 20'(r_key_bits);
        w_bits_min  = (w_bits < 20'(bfiq_pkg::MIN_FILTER_BITS))
                      ? 20'(bfiq_pkg::MIN_FILTER_BITS) : w_bits;
        w_bytes_raw = (w_bits_min + 20'd7) >> 3;
    end

    always_ff @(posedge i_clk) begin
        if (w_bytes_raw > 20'(bfiq_pkg::MAX_FILTER_BYTES))
            r_num_bytes <= bfiq_pkg::BYTES_W'(bfiq_pkg::MAX_FILTER_BYTES);
        else
            r_num_bytes <= w_bytes_raw[bfiq_pkg::BYTES_W-1:0];
    end

    // Probe count clamped to 1..MAX_PROBES
    always_comb begin
        if (r_probe_count == '0)
            w_num_probes = bfiq_pkg::PROBE_W'(1);
        else if (r_probe_count > bfiq_pkg::PROBE_W'(bfiq_pkg::MAX_PROBES))
            w_num_probes = bfiq_pkg::PROBE_W'(bfiq_pkg::MAX_PROBES);
        else
            w_num_probes = r_probe_count;
    end

    // Captured input word and probe hash state
    logic [bfiq_pkg::ACT_W-1:0]     r_action;
    logic [bfiq_pkg::HASH_W-1:0]    r_hash;
    logic [bfiq_pkg::HASH_W-1:0]    r_delta;
    logic [bfiq_pkg::ADDR_W-1:0]    r_index;
    logic [7:0]                     r_value;
    logic [bfiq_pkg::HASH_W-1:0]    w_next_hash;
    logic [bfiq_pkg::HASH_W-1:0]    w_div_src;
    // Remainder unit: quotient bits shift out, remainder is the byte address
    logic [bfiq_pkg::DIV_STEPS-1:0] r_quot;
    logic [bfiq_pkg::ADDR_W-1:0]    r_rem;
    logic [2:0]                     r_low;
    logic [bfiq_pkg::ADDR_W:0]      w_rem2;
    // Result working registers
    logic                           r_miss;
    logic [7:0]                     r_byte;
    logic                           r_err;
    // Store access
    logic [7:0]                     r_mem [bfiq_pkg::MAX_FILTER_BYTES];
    logic [7:0]                     r_rdata;
    logic [bfiq_pkg::ADDR_W-1:0]    r_clr_addr;
    logic [bfiq_pkg::ADDR_W-1:0]    w_addr;
    logic                           w_we;
    logic [7:0]                     w_wdata;
    logic [7:0]                     w_mask;
    logic                           w_is_insert;

    assign w_next_hash = r_hash + r_delta;
    assign w_div_src   = i_cmd.load ? i_key_hash : w_next_hash;
    assign w_rem2      = {r_rem, r_quot[bfiq_pkg::DIV_STEPS-1]};
    assign w_mask      = 8'(1) << r_low;
    assign w_is_insert = (r_action == bfiq_pkg::ACT_INSERT);

    // Input capture, hash stepping and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_hash   <= i_key_hash;
            r_delta  <= {i_key_hash[16:0], i_key_hash[31:17]};
            r_index  <= i_byte_index;
            r_value  <= i_byte_value;
        end else if (i_cmd.probe_chk) begin
            r_hash   <= w_next_hash;
        end
        if (i_cmd.load || i_cmd.probe_chk) begin
            r_quot <= w_div_src[bfiq_pkg::HASH_W-1:3];
            r_rem  <= '0;
            r_low  <= w_div_src[2:0];
        end else if (i_cmd.div_step) begin
            r_quot <= r_quot << 1;
            if (w_rem2 >= (bfiq_pkg::ADDR_W+1)'(r_num_bytes))
                r_rem <= bfiq_pkg::ADDR_W'(w_rem2 - (bfiq_pkg::ADDR_W+1)'(r_num_bytes));
            else
                r_rem <= w_rem2[bfiq_pkg::ADDR_W-1:0];
        end
    end

    // Result working values
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_miss <= 1'b0;
            r_byte <= '0;
            r_err  <= 1'b0;
        end else begin
            if (i_cmd.probe_chk && (r_action == bfiq_pkg::ACT_QUERY) && ((r_rdata & w_mask) == '0))
                r_miss <= 1'b1;
            if (i_cmd.byte_cap)
                r_byte <= r_rdata;
            if (i_cmd.set_err)
                r_err <= 1'b1;
        end
    end

    // Clear sweep address; wraps back to zero after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_clr_addr <= '0;
        else if (i_cmd.clr_step)
            r_clr_addr <= r_clr_addr + 1'b1;
    end

    // Store port selection
    always_comb begin
        if (i_cmd.clr_step) begin
            w_addr  = r_clr_addr;
            w_we    = 1'b1;
            w_wdata = '0;
        end else if (i_cmd.rd_probe || i_cmd.probe_chk) begin
            w_addr  = r_rem;
            w_we    = i_cmd.probe_chk && w_is_insert;
            w_wdata = r_rdata | w_mask;
        end else begin
            w_addr  = r_index;
            w_we    = i_cmd.wr_byte;
            w_wdata = r_value;
        end
    end

    // Filter store, one port, registered read on request
    always_ff @(posedge i_clk) begin
        if (w_we)
            r_mem[w_addr] <= w_wdata;
        if (i_cmd.rd_probe || i_cmd.rd_byte)
            r_rdata <= r_mem[w_addr];
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_may_match   <= (r_action == bfiq_pkg::ACT_QUERY) && !r_miss;
            o_byte_out    <= r_byte;
            o_index_error <= r_err;
        end
    end

    // Status to controller
    always_comb begin
        o_status.action     = r_action;
        o_status.idx_ok     = (bfiq_pkg::BYTES_W'(r_index) < r_num_bytes);
        o_status.bit_set    = ((r_rdata & w_mask) != '0);
        o_status.clr_last   = (r_clr_addr == bfiq_pkg::ADDR_W'(bfiq_pkg::MAX_FILTER_BYTES - 1));
        o_status.out_busy   = o_out_valid && !i_out_ready;
        o_status.num_probes = w_num_probes;
    end

endmodule
`default_nettype wire

// File: sv/bfiq_ctrl.sv
// Controller: state machine sequencing clears, probe walks and byte accesses.
`default_nettype none
module bfiq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire bfiq_pkg::t_status i_status,
    output bfiq_pkg::t_cmd         o_cmd
);

    bfiq_pkg::t_state             r_state, n_state;
    logic [bfiq_pkg::STEP_W-1:0]  r_step,  n_step;
    logic [bfiq_pkg::PROBE_W-1:0] r_probe, n_probe;
    logic                         w_div_last;
    logic                         w_probe_last;
    logic                         w_is_probe;

    assign w_div_last   = (r_step == bfiq_pkg::STEP_W'(bfiq_pkg::DIV_STEPS - 1));
    assign w_probe_last = (r_probe == i_status.num_probes - 1'b1);
    assign w_is_probe   = (i_status.action == bfiq_pkg::ACT_INSERT)
                       || (i_status.action == bfiq_pkg::ACT_QUERY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfiq_pkg::ST_INIT;
            r_step  <= '0;
            r_probe <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_probe <= n_probe;
        end
    end

    // Next state and counters
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_probe = r_probe;
        case (r_state)
            bfiq_pkg::ST_INIT: begin
                if (i_status.clr_last)
                    n_state = bfiq_pkg::ST_IDLE;
            end
            bfiq_pkg::ST_IDLE: begin
                if (i_in_valid)
                    n_state = bfiq_pkg::ST_DECODE;
            end
            bfiq_pkg::ST_DECODE: begin
                n_step  = '0;
                n_probe = '0;
                case (i_status.action)
                    bfiq_pkg::ACT_CLEAR: n_state = bfiq_pkg::ST_CLEAR;
                    bfiq_pkg::ACT_READ:
                        n_state = i_status.idx_ok ? bfiq_pkg::ST_BYTE : bfiq_pkg::ST_DONE;
                    default:
                        n_state = w_is_probe ? bfiq_pkg::ST_DIV : bfiq_pkg::ST_DONE;
                endcase
            end
            bfiq_pkg::ST_CLEAR: begin
                if (i_status.clr_last)
                    n_state = bfiq_pkg::ST_DONE;
            end
            bfiq_pkg::ST_DIV: begin
                if (w_div_last) begin
                    n_step  = '0;
                    n_state = bfiq_pkg::ST_RD;
                end else begin
                    n_step  = r_step + 1'b1;
                end
            end
            bfiq_pkg::ST_RD: begin
                n_state = bfiq_pkg::ST_CHK;
            end
            bfiq_pkg::ST_CHK: begin
                // a query stops at its first clear bit
                if (w_probe_last ||
                    ((i_status.action == bfiq_pkg::ACT_QUERY) && !i_status.bit_set)) begin
                    n_state = bfiq_pkg::ST_DONE;
                end else begin
                    n_probe = r_probe + 1'b1;
                    n_state = bfiq_pkg::ST_DIV;
                end
            end
            bfiq_pkg::ST_BYTE: begin
                n_state = bfiq_pkg::ST_DONE;
            end
            bfiq_pkg::ST_DONE: begin
                if (!i_status.out_busy)
                    n_state = bfiq_pkg::ST_IDLE;
            end
            default: n_state = bfiq_pkg::ST_INIT;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            bfiq_pkg::ST_INIT:  o_cmd.clr_step = 1'b1;
            bfiq_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            bfiq_pkg::ST_DECODE: begin
                if ((i_status.action == bfiq_pkg::ACT_READ) ||
                    (i_status.action == bfiq_pkg::ACT_WRITE)) begin
                    o_cmd.set_err = !i_status.idx_ok;
                    o_cmd.rd_byte = i_status.idx_ok && (i_status.action == bfiq_pkg::ACT_READ);
                    o_cmd.wr_byte = i_status.idx_ok && (i_status.action == bfiq_pkg::ACT_WRITE);
                end
            end
            bfiq_pkg::ST_CLEAR: o_cmd.clr_step  = 1'b1;
            bfiq_pkg::ST_DIV:   o_cmd.div_step  = 1'b1;
            bfiq_pkg::ST_RD:    o_cmd.rd_probe  = 1'b1;
            bfiq_pkg::ST_CHK:   o_cmd.probe_chk = 1'b1;
            bfiq_pkg::ST_BYTE:  o_cmd.byte_cap  = 1'b1;
            bfiq_pkg::ST_DONE:  o_cmd.out_load  = !i_status.out_busy;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: sv/bloom_filter_insert_query_core.sv
// Top level of the Bloom filter insert/query core: controller plus datapath.
//
// Input channel (i_in_valid/o_in_ready) carries one word: action, key hash,
// byte index and byte value. Result channel (o_out_valid/i_out_ready) gives
// exactly one word per input word: may_match, byte_out, index_error.
// Configuration channel (i_cfg_valid/o_cfg_ready, always ready) writes
// bits per key (index 0), key_count (1) and probe_count (2); other indexes
// are ignored. Write configuration only while the core is idle.
// Sequence after acceptance: write byte and unused action codes go from decode
// straight to the result, read byte adds a capture state, clear zeroes all 512
// store bytes (one store byte zeroed per cycle), and insert/query run each probe
// as a 29-step bit-serial remainder against the byte count followed by a read
// and a check on the single store port. A query stops at the first clear bit.
// One word is in flight at a time; o_in_ready is high only when idle, and the
// next word is taken in the cycle after a result is loaded.
// After reset all 512 store bytes are swept to zero with o_in_ready low.
// The result sits in an output register; the core returns to idle and takes
// the next word while it waits, but holds a new result until it is taken.
`default_nettype none
module bloom_filter_insert_query_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [bfiq_pkg::ACT_W-1:0]      i_action,
    input  wire logic [bfiq_pkg::HASH_W-1:0]     i_key_hash,
    input  wire logic [bfiq_pkg::ADDR_W-1:0]     i_byte_index,
    input  wire logic [7:0]                      i_byte_value,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic                                 o_may_match,
    output logic [7:0]                           o_byte_out,
    output logic                                 o_index_error,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [bfiq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bfiq_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    bfiq_pkg::t_cmd    w_cmd;
    bfiq_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;

    bfiq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    bfiq_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_action      (i_action),
        .i_key_hash    (i_key_hash),
        .i_byte_index  (i_byte_index),
        .i_byte_value  (i_byte_value),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_may_match   (o_may_match),
        .o_byte_out    (o_byte_out),
        .o_index_error (o_index_error)
    );

endmodule
`default_nettype wire
